// ===== src/sfs_pkg.sv =====
// Shared types, codes and constants for the sprite frame sequencer.
`timescale 1ns / 1ps
package sfs_pkg;

  // fixed field and register widths
  localparam int MODE_W      = 2;
  localparam int DELTA_W     = 16;
  localparam int ANIM_W      = 3;
  localparam int PERIOD_W    = 16;
  localparam int COLS_W      = 7;
  localparam int CELL_W      = 11;
  localparam int OSEL_W      = 4;
  localparam int FRAME_OUT_W = 12;
  localparam int POS_W       = 16;
  localparam int ORG_W       = 12;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // command codes
  localparam logic [MODE_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] CMD_PLAY  = 2'd1;
  localparam logic [MODE_W-1:0] CMD_MODE  = 2'd2;
  localparam logic [MODE_W-1:0] CMD_PAUSE = 2'd3;

  // animation modes
  localparam logic [ANIM_W-1:0] ANIM_LOOP_FWD = 3'd0;
  localparam logic [ANIM_W-1:0] ANIM_LOOP_BWD = 3'd1;
  localparam logic [ANIM_W-1:0] ANIM_ONCE_FWD = 3'd2;
  localparam logic [ANIM_W-1:0] ANIM_ONCE_BWD = 3'd3;

  // register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_COLS   = 3'd2;
  localparam logic [2:0] REG_ROWS   = 3'd3;
  localparam logic [2:0] REG_CELL_W = 3'd4;
  localparam logic [2:0] REG_CELL_H = 3'd5;
  localparam logic [2:0] REG_ORIGIN = 3'd6;

  // register reset values and the cell size limit
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd100;
  localparam logic [COLS_W-1:0]   RST_GRID   = 7'd1;
  localparam logic [CELL_W-1:0]   RST_CELL   = 11'd16;
  localparam logic [CELL_W-1:0]   CELL_MAX   = 11'd1024;

  // origin position along one axis
  localparam logic [1:0] ORG_NEAR = 2'd0;
  localparam logic [1:0] ORG_MID  = 2'd1;
  localparam logic [1:0] ORG_FAR  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EDIV,
    S_RDIV,
    S_FINISH,
    S_XYGO,
    S_XYDIV,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_ELAPSED,
    DIV_WRAP,
    DIV_CELL
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_e;
    logic     cap_r;
    logic     finish;
    logic     cap_xy;
    logic     out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic fire;
    logic adv;
    logic div_done;
  } ctl_sts_t;

  function automatic logic [1:0] org_col(input logic [OSEL_W-1:0] sel);
    logic [1:0] c;
    unique case (sel) inside
      4'd1, 4'd4, 4'd7: c = ORG_MID;
      4'd2, 4'd5, 4'd8: c = ORG_FAR;
      default:          c = ORG_NEAR;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] org_row(input logic [OSEL_W-1:0] sel);
    logic [1:0] r;
    unique case (sel) inside
      4'd3, 4'd4, 4'd5: r = ORG_MID;
      4'd6, 4'd7, 4'd8: r = ORG_FAR;
      default:          r = ORG_NEAR;
    endcase
    return r;
  endfunction

  // 0, size or twice size, in half-pixels
  function automatic logic [ORG_W-1:0] org_half(input logic [1:0] pos,
                                                input logic [CELL_W-1:0] size);
    logic [ORG_W-1:0] v;
    unique case (pos)
      ORG_MID: v = {1'b0, size};
      ORG_FAR: v = {size, 1'b0};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/sfs_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sfs_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    take  = trial >= {1'b0, den_r};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out of quo_r as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== src/sfs_dp.sv =====
// Datapath: animation state, command execution, frame advance and cell math.
`timescale 1ns / 1ps
module sfs_dp #(
  parameter int MAX_GRID  = 64,
  parameter int TIME_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sfs_pkg::ctl_cmd_t               cmd,
  output sfs_pkg::ctl_sts_t               sts,
  input  logic                            cfg_en,
  input  logic [sfs_pkg::PERIOD_W-1:0]    cfg_period,
  input  logic [sfs_pkg::COLS_W-1:0]      cfg_cols,
  input  logic [sfs_pkg::COLS_W-1:0]      cfg_rows,
  input  logic [sfs_pkg::CELL_W-1:0]      cfg_cw,
  input  logic [sfs_pkg::CELL_W-1:0]      cfg_ch,
  input  logic [sfs_pkg::OSEL_W-1:0]      cfg_osel,
  input  logic [sfs_pkg::MODE_W-1:0]      in_mode,
  input  logic [sfs_pkg::DELTA_W-1:0]     in_delta_ms,
  input  logic [sfs_pkg::ANIM_W-1:0]      in_anim_mode,
  input  logic                            in_pause_flag,
  output logic [sfs_pkg::FRAME_OUT_W-1:0] out_frame_index,
  output logic [sfs_pkg::POS_W-1:0]       out_cell_x,
  output logic [sfs_pkg::POS_W-1:0]       out_cell_y,
  output logic [sfs_pkg::ORG_W-1:0]       out_origin_x_half,
  output logic [sfs_pkg::ORG_W-1:0]       out_origin_y_half,
  output logic                            out_playing
);

  localparam int ColsMax = (1 << sfs_pkg::COLS_W) - 1;
  localparam int GridEff = (MAX_GRID < ColsMax) ? MAX_GRID : ColsMax;
  localparam int GC_W    = $clog2(GridEff + 1);
  localparam int CNT_W   = $clog2(GridEff * GridEff + 1);
  localparam int FRM_W   = (GridEff > 1) ? $clog2(GridEff * GridEff) : 1;
  localparam int NUM_W   = (TIME_BITS > FRM_W) ? TIME_BITS : FRM_W;
  localparam int DEN_W   = sfs_pkg::PERIOD_W;
  localparam int SUM_W   = NUM_W + 1;
  localparam int ACC_W   = ((TIME_BITS > sfs_pkg::DELTA_W) ? TIME_BITS : sfs_pkg::DELTA_W) + 1;
  localparam int CW      = sfs_pkg::CELL_W;
  localparam int CL_W    = sfs_pkg::COLS_W;
  localparam logic [TIME_BITS-1:0] ACC_MAX = '1;

  // animation state
  logic [FRM_W-1:0]            frame_r;
  logic [TIME_BITS-1:0]        accum_r;
  logic                        playing_r;
  logic                        paused_r;
  logic [sfs_pkg::ANIM_W-1:0]  mode_r;
  logic                        fire_r;

  // per-item working values
  logic [CNT_W-1:0]     n_r;
  logic [TIME_BITS-1:0] e_r;
  logic [CNT_W-1:0]     r_r;
  logic [GC_W-1:0]      col_r;
  logic [GC_W-1:0]      row_r;

  // clamped configuration
  logic [CL_W-1:0]         cols_c, rows_c;
  logic [GC_W-1:0]         cols_eff, rows_eff;
  logic [2*GC_W-1:0]       n_prod;
  logic [CNT_W-1:0]        n_cur, n_m1, frame_ext;
  logic [FRM_W-1:0]        frame_cl, frame_play;
  logic [CW-1:0]           cw_eff, ch_eff;
  logic [DEN_W-1:0]        period_eff;

  // tick
  logic [ACC_W-1:0]     acc_sum;
  logic [TIME_BITS-1:0] acc_sat;
  logic                 fire_now;

  // frame advance
  logic [SUM_W-1:0] f_s, e_s, r_s, n_s;
  logic [SUM_W-1:0] fwd_sum, wrap_f, wrap_f2, wrap_b;
  logic [CNT_W-1:0] nr_m1;
  logic [FRM_W-1:0] frame_fin;
  logic             playing_fin;
  logic             adv;

  // divider
  logic             div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;

  // output products
  logic [GC_W+CW-1:0] prod_x, prod_y;
  logic [sfs_pkg::OSEL_W-1:0] osel_eff;

  always_comb begin
    cols_c = (cfg_cols == '0) ? CL_W'(1)
           : ((cfg_cols > CL_W'(GridEff)) ? CL_W'(GridEff) : cfg_cols);
    rows_c = (cfg_rows == '0) ? CL_W'(1)
           : ((cfg_rows > CL_W'(GridEff)) ? CL_W'(GridEff) : cfg_rows);
    cols_eff = cols_c[GC_W-1:0];
    rows_eff = rows_c[GC_W-1:0];
    n_prod   = {{GC_W{1'b0}}, cols_eff} * {{GC_W{1'b0}}, rows_eff};
    n_cur    = n_prod[CNT_W-1:0];
    n_m1     = n_cur - CNT_W'(1);
    frame_ext = CNT_W'(frame_r);
    frame_cl  = (frame_ext >= n_cur) ? n_m1[FRM_W-1:0] : frame_r;
    frame_play = (in_anim_mode == sfs_pkg::ANIM_LOOP_BWD ||
                  in_anim_mode == sfs_pkg::ANIM_ONCE_BWD) ? n_m1[FRM_W-1:0] : '0;

    cw_eff = (cfg_cw == '0) ? CW'(1)
           : ((cfg_cw > sfs_pkg::CELL_MAX) ? sfs_pkg::CELL_MAX : cfg_cw);
    ch_eff = (cfg_ch == '0) ? CW'(1)
           : ((cfg_ch > sfs_pkg::CELL_MAX) ? sfs_pkg::CELL_MAX : cfg_ch);
    period_eff = (cfg_period == '0) ? DEN_W'(1) : cfg_period;
    osel_eff   = (cfg_osel > 4'd8) ? '0 : cfg_osel;

    acc_sum  = ACC_W'(accum_r) + ACC_W'(in_delta_ms);
    acc_sat  = (acc_sum > ACC_W'(ACC_MAX)) ? ACC_MAX : acc_sum[TIME_BITS-1:0];
    fire_now = !paused_r && (ACC_W'(acc_sat) >= ACC_W'(cfg_period));
  end

  // frame advance by e frames, r = e mod n
  always_comb begin
    f_s     = SUM_W'(frame_r);
    e_s     = SUM_W'(e_r);
    r_s     = SUM_W'(r_r);
    n_s     = SUM_W'(n_r);
    nr_m1   = n_r - CNT_W'(1);
    fwd_sum = f_s + e_s;
    wrap_f  = f_s + r_s;
    wrap_f2 = (wrap_f >= n_s) ? (wrap_f - n_s) : wrap_f;
    wrap_b  = (f_s >= r_s) ? (f_s - r_s) : (f_s + n_s - r_s);
    adv     = playing_r && (mode_r <= sfs_pkg::ANIM_ONCE_BWD);
    frame_fin   = frame_r;
    playing_fin = playing_r;
    case (mode_r) inside
      sfs_pkg::ANIM_LOOP_FWD, sfs_pkg::ANIM_ONCE_FWD: begin
        if (fwd_sum >= n_s) begin
          if (mode_r == sfs_pkg::ANIM_LOOP_FWD) begin
            frame_fin = wrap_f2[FRM_W-1:0];
          end else begin
            frame_fin   = nr_m1[FRM_W-1:0];
            playing_fin = 1'b0;
          end
        end else begin
          frame_fin = fwd_sum[FRM_W-1:0];
        end
      end
      sfs_pkg::ANIM_LOOP_BWD, sfs_pkg::ANIM_ONCE_BWD: begin
        if (e_s > f_s) begin
          if (mode_r == sfs_pkg::ANIM_LOOP_BWD) begin
            frame_fin = wrap_b[FRM_W-1:0];
          end else begin
            frame_fin   = '0;
            playing_fin = 1'b0;
          end
        end else begin
          frame_fin = FRM_W'(f_s - e_s);
        end
      end
      default: begin
        frame_fin   = frame_r;
        playing_fin = playing_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r   <= '0;
      accum_r   <= '0;
      playing_r <= 1'b0;
      paused_r  <= 1'b0;
      mode_r    <= sfs_pkg::ANIM_LOOP_FWD;
      fire_r    <= 1'b0;
    end else if (cmd.load) begin
      // a register change may leave the frame past the end of the grid
      frame_r <= frame_cl;
      fire_r  <= 1'b0;
      if (cfg_en) begin
        unique case (in_mode)
          sfs_pkg::CMD_TICK: begin
            accum_r <= acc_sat;
            fire_r  <= fire_now;
          end
          sfs_pkg::CMD_PLAY: begin
            mode_r    <= in_anim_mode;
            playing_r <= 1'b1;
            accum_r   <= '0;
            frame_r   <= frame_play;
          end
          sfs_pkg::CMD_MODE: mode_r <= in_anim_mode;
          sfs_pkg::CMD_PAUSE: paused_r <= in_pause_flag;
          default: ;
        endcase
      end
    end else if (cmd.finish) begin
      accum_r <= '0;
      if (adv) begin
        frame_r   <= frame_fin;
        playing_r <= playing_fin;
      end
    end
  end

  always_comb begin
    case (cmd.div_sel)
      sfs_pkg::DIV_ELAPSED: begin
        div_num = NUM_W'(accum_r);
        div_den = period_eff;
      end
      sfs_pkg::DIV_WRAP: begin
        div_num = div_quo;
        div_den = DEN_W'(n_r);
      end
      default: begin
        div_num = NUM_W'(frame_r);
        div_den = DEN_W'(cols_eff);
      end
    endcase
  end

  sfs_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= n_cur;
    end
    if (cmd.cap_e) begin
      e_r <= div_quo[TIME_BITS-1:0];
    end
    if (cmd.cap_r) begin
      r_r <= div_rem[CNT_W-1:0];
    end
    if (cmd.cap_xy) begin
      row_r <= div_quo[GC_W-1:0];
      col_r <= div_rem[GC_W-1:0];
    end
  end

  always_comb begin
    prod_x = {{CW{1'b0}}, col_r} * {{GC_W{1'b0}}, cw_eff};
    prod_y = {{CW{1'b0}}, row_r} * {{GC_W{1'b0}}, ch_eff};
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_frame_index   <= sfs_pkg::FRAME_OUT_W'(frame_r);
      out_cell_x        <= sfs_pkg::POS_W'(prod_x);
      out_cell_y        <= sfs_pkg::POS_W'(prod_y);
      out_origin_x_half <= sfs_pkg::org_half(sfs_pkg::org_col(osel_eff), cw_eff);
      out_origin_y_half <= sfs_pkg::org_half(sfs_pkg::org_row(osel_eff), ch_eff);
      out_playing       <= playing_r;
    end
  end

  assign sts.fire     = fire_r;
  assign sts.adv      = adv;
  assign sts.div_done = div_done;

endmodule

// ===== src/sfs_ctrl.sv =====
// Controller: sequences accept, frame advance, cell divide and result beat.
`timescale 1ns / 1ps
module sfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sfs_pkg::ctl_sts_t sts,
  output sfs_pkg::ctl_cmd_t cmd
);

  sfs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = sfs_pkg::DIV_CELL;
    unique case (state_r)
      sfs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sfs_pkg::S_CHECK;
        end
      end
      sfs_pkg::S_CHECK: begin
        if (sts.fire && sts.adv) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = sfs_pkg::DIV_ELAPSED;
          state_nxt     = sfs_pkg::S_EDIV;
        end else if (sts.fire) begin
          state_nxt = sfs_pkg::S_FINISH;
        end else begin
          state_nxt = sfs_pkg::S_XYGO;
        end
      end
      sfs_pkg::S_EDIV: begin
        // quotient feeds the wrap divide straight away
        if (sts.div_done) begin
          cmd.cap_e     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = sfs_pkg::DIV_WRAP;
          state_nxt     = sfs_pkg::S_RDIV;
        end
      end
      sfs_pkg::S_RDIV: begin
        if (sts.div_done) begin
          cmd.cap_r = 1'b1;
          state_nxt = sfs_pkg::S_FINISH;
        end
      end
      sfs_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = sfs_pkg::S_XYGO;
      end
      sfs_pkg::S_XYGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = sfs_pkg::DIV_CELL;
        state_nxt     = sfs_pkg::S_XYDIV;
      end
      sfs_pkg::S_XYDIV: begin
        if (sts.div_done) begin
          cmd.cap_xy = 1'b1;
          state_nxt  = sfs_pkg::S_DONE;
        end
      end
      sfs_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = sfs_pkg::S_IDLE;
        end
      end
      default: state_nxt = sfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = (state_r != sfs_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/sprite_frame_sequencer.sv =====
// Top level: register port, controller and datapath of the sprite frame sequencer.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   in      | in_valid/in_stall, mode/delta/anim/pause | command beat in
//   out     | out_valid/out_stall, frame/cell/origin   | frame beat out
//   cfg     | cfg_psel/penable/pwrite/paddr/pwdata    | register write/read
//
// One command at a time. Every command ends with the cell-position divide; a tick that
// reaches the period also passes the finish state, and an advancing tick first runs the
// elapsed and wrap divides. All three divides share the one-bit-per-cycle divider. The
// next accept can follow in the cycle after the result beat is loaded. A waiting result
// beat stalls the next command in its last state.
// Reset (synchronous, rst_n low) restores register defaults and clears the player state.
`timescale 1ns / 1ps
module sprite_frame_sequencer #(
  parameter int MAX_GRID  = 64,
  parameter int TIME_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sfs_pkg::MODE_W-1:0]      in_mode,
  input  logic [sfs_pkg::DELTA_W-1:0]     in_delta_ms,
  input  logic [sfs_pkg::ANIM_W-1:0]      in_anim_mode,
  input  logic                            in_pause_flag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sfs_pkg::FRAME_OUT_W-1:0] out_frame_index,
  output logic [sfs_pkg::POS_W-1:0]       out_cell_x,
  output logic [sfs_pkg::POS_W-1:0]       out_cell_y,
  output logic [sfs_pkg::ORG_W-1:0]       out_origin_x_half,
  output logic [sfs_pkg::ORG_W-1:0]       out_origin_y_half,
  output logic                            out_playing,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [sfs_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [sfs_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [sfs_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);

  logic                         en_r;
  logic [sfs_pkg::PERIOD_W-1:0] period_r;
  logic [sfs_pkg::COLS_W-1:0]   cols_r;
  logic [sfs_pkg::COLS_W-1:0]   rows_r;
  logic [sfs_pkg::CELL_W-1:0]   cw_r;
  logic [sfs_pkg::CELL_W-1:0]   ch_r;
  logic [sfs_pkg::OSEL_W-1:0]   osel_r;

  logic       wr_en;
  logic [2:0] reg_idx;

  sfs_pkg::ctl_cmd_t cmd;
  sfs_pkg::ctl_sts_t sts;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[sfs_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b1;
      period_r <= sfs_pkg::RST_PERIOD;
      cols_r   <= sfs_pkg::RST_GRID;
      rows_r   <= sfs_pkg::RST_GRID;
      cw_r     <= sfs_pkg::RST_CELL;
      ch_r     <= sfs_pkg::RST_CELL;
      osel_r   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sfs_pkg::REG_ENABLE: en_r     <= cfg_pwdata[0];
        sfs_pkg::REG_PERIOD: period_r <= cfg_pwdata[sfs_pkg::PERIOD_W-1:0];
        sfs_pkg::REG_COLS:   cols_r   <= cfg_pwdata[sfs_pkg::COLS_W-1:0];
        sfs_pkg::REG_ROWS:   rows_r   <= cfg_pwdata[sfs_pkg::COLS_W-1:0];
        sfs_pkg::REG_CELL_W: cw_r     <= cfg_pwdata[sfs_pkg::CELL_W-1:0];
        sfs_pkg::REG_CELL_H: ch_r     <= cfg_pwdata[sfs_pkg::CELL_W-1:0];
        sfs_pkg::REG_ORIGIN: osel_r   <= cfg_pwdata[sfs_pkg::OSEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sfs_pkg::REG_ENABLE: cfg_prdata = sfs_pkg::DATA_W'(en_r);
      sfs_pkg::REG_PERIOD: cfg_prdata = sfs_pkg::DATA_W'(period_r);
      sfs_pkg::REG_COLS:   cfg_prdata = sfs_pkg::DATA_W'(cols_r);
      sfs_pkg::REG_ROWS:   cfg_prdata = sfs_pkg::DATA_W'(rows_r);
      sfs_pkg::REG_CELL_W: cfg_prdata = sfs_pkg::DATA_W'(cw_r);
      sfs_pkg::REG_CELL_H: cfg_prdata = sfs_pkg::DATA_W'(ch_r);
      sfs_pkg::REG_ORIGIN: cfg_prdata = sfs_pkg::DATA_W'(osel_r);
      default:             cfg_prdata = '0;
    endcase
  end

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfs_dp #(
    .MAX_GRID (MAX_GRID),
    .TIME_BITS(TIME_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_en           (en_r),
    .cfg_period       (period_r),
    .cfg_cols         (cols_r),
    .cfg_rows         (rows_r),
    .cfg_cw           (cw_r),
    .cfg_ch           (ch_r),
    .cfg_osel         (osel_r),
    .in_mode          (in_mode),
    .in_delta_ms      (in_delta_ms),
    .in_anim_mode     (in_anim_mode),
    .in_pause_flag    (in_pause_flag),
    .out_frame_index  (out_frame_index),
    .out_cell_x       (out_cell_x),
    .out_cell_y       (out_cell_y),
    .out_origin_x_half(out_origin_x_half),
    .out_origin_y_half(out_origin_y_half),
    .out_playing      (out_playing)
  );

endmodule
